@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sps_pkg.sv @@
`default_nettype none
package sps_pkg;

	localparam int NUM_SERVOS = 4;
	localparam int PULSE_W    = 12;
	localparam int SPEED_W    = 14;
	localparam int ANGLE_W    = 8;
	localparam int POSE_W     = 3;
	localparam int CFG_IDX_W  = 3;

	// Fraction bits of the fixed-point reciprocal used for the step size.
	localparam int STEP_FRAC  = 24;
	localparam int STEP_MUL_W = STEP_FRAC + 2;

	localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(1000);
	localparam logic [PULSE_W-1:0] PULSE_MIN   = PULSE_W'(500);
	localparam logic [PULSE_W-1:0] PULSE_MAX   = PULSE_W'(2500);
	localparam logic [PULSE_W-1:0] PULSE_MID   = PULSE_W'(1500);
	localparam logic [ANGLE_W-1:0] ANGLE_MAX   = ANGLE_W'(180);

	// floor(x / 9) = (x * 7282) >> 16, exact for x below 32768.
	localparam int               DIV9_SHIFT = 16;
	localparam logic [12:0]      DIV9_MULT  = 13'd7282;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_FIRST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_SECOND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_THIRD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_FOURTH = 3'd4;

	localparam logic [POSE_W-1:0] POSE_CUSTOM = 3'd5;

	typedef logic [PULSE_W-1:0] pulse_t;
	typedef pulse_t [NUM_SERVOS-1:0] pulse_set_t;

	// Preset target pulses, already converted from their angles.
	// home (150,150,0,90), open (60,60,45,120), close (105,105,45,120),
	// fly (105,105,0,90), throw (60,60,0,90); servo 0 in the lowest slot.
	localparam pulse_set_t PRESET_PULSE [POSE_CUSTOM] = '{
		'{12'd1500, 12'd500,  12'd2166, 12'd2166},
		'{12'd1833, 12'd1000, 12'd1166, 12'd1166},
		'{12'd1833, 12'd1000, 12'd1666, 12'd1666},
		'{12'd1500, 12'd500,  12'd1666, 12'd1666},
		'{12'd1500, 12'd500,  12'd1166, 12'd1166}
	};

	// Settings carried from the configuration registers to the datapath.
	typedef struct packed {
		logic [SPEED_W-1:0] step;
		pulse_set_t         custom_tgt;
	} sps_cfg_t;

	function automatic pulse_t angle_to_pulse(input logic [ANGLE_W-1:0] angle);
		logic [ANGLE_W-1:0] a;
		logic [14:0]        scaled;
		logic [27:0]        prod;
		a      = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
		scaled = 15'(a) * 15'd100;
		prod   = 28'(scaled) * 28'(DIV9_MULT);
		return PULSE_MIN + PULSE_W'(prod >> DIV9_SHIFT);
	endfunction

endpackage
`default_nettype wire

@@ hdl/sps_cfg.sv @@
`default_nettype none
module sps_cfg #(
	parameter int STEP_MS = 20
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [sps_pkg::SPEED_W-1:0]     cfg_wdata,
	output sps_pkg::sps_cfg_t               cfg
);
	import sps_pkg::*;

	// step = floor(speed * STEP_MS / 1000) as one multiply by a rounded-up
	// reciprocal; exact because speed * 1000 stays below 2^STEP_FRAC.
	localparam logic [STEP_MUL_W-1:0] STEP_MULT =
		STEP_MUL_W'((64'(STEP_MS) * (64'd1 << STEP_FRAC) + 64'd999) / 64'd1000);
	localparam logic [SPEED_W-1:0] RESET_STEP =
		SPEED_W'((64'(SPEED_RESET) * 64'(STEP_MS)) / 64'd1000);

	localparam int PROD_W = SPEED_W + STEP_MUL_W;

	logic [SPEED_W-1:0] step_q;
	pulse_set_t         tgt_q;
	logic [PROD_W-1:0]  step_prod;
	pulse_t             wr_pulse;

	assign step_prod = PROD_W'(cfg_wdata) * PROD_W'(STEP_MULT);
	assign wr_pulse  = angle_to_pulse(cfg_wdata[ANGLE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= RESET_STEP;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				tgt_q[i] <= PULSE_MID;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLEW_SPEED:    step_q   <= step_prod[STEP_FRAC +: SPEED_W];
				CFG_CUSTOM_FIRST:  tgt_q[0] <= wr_pulse;
				CFG_CUSTOM_SECOND: tgt_q[1] <= wr_pulse;
				CFG_CUSTOM_THIRD:  tgt_q[2] <= wr_pulse;
				CFG_CUSTOM_FOURTH: tgt_q[3] <= wr_pulse;
				default: ;
			endcase
		end
	end

	assign cfg.step       = step_q;
	assign cfg.custom_tgt = tgt_q;

endmodule
`default_nettype wire

@@ hdl/sps_step.sv @@
`default_nettype none
module sps_step (
	input  wire  [sps_pkg::PULSE_W-1:0] cur_raw,
	input  wire  [sps_pkg::PULSE_W-1:0] tgt,
	input  wire                         hold,
	input  wire  [sps_pkg::SPEED_W-1:0] step,
	output logic [sps_pkg::PULSE_W-1:0] nxt,
	output logic                        at_tgt
);
	import sps_pkg::*;

	pulse_t             cur;
	pulse_t             goal;
	pulse_t             gap;
	logic               up;

	always_comb begin
		if (cur_raw < PULSE_MIN) begin
			cur = PULSE_MIN;
		end else if (cur_raw > PULSE_MAX) begin
			cur = PULSE_MAX;
		end else begin
			cur = cur_raw;
		end
		goal = hold ? cur : tgt;
		up   = goal > cur;
		gap  = up ? (goal - cur) : (cur - goal);
		// Land on the target when it is within one step; both values sit in
		// 500..2500, so a partial step never leaves that range.
		if (SPEED_W'(gap) <= step) begin
			nxt = goal;
		end else if (up) begin
			nxt = cur + PULSE_W'(step);
		end else begin
			nxt = cur - PULSE_W'(step);
		end
		at_tgt = (nxt == goal);
	end

endmodule
`default_nettype wire

@@ hdl/servo_pose_slew_limiter.sv @@
`default_nettype none
// Channel  Dir  Width  Contents
// s_axis   in   8      tdata[2:0] pose, tick that names a pose
// m_axis   out  56     tdata: four 12-bit pulse widths, then settled
// cfg      in   1+3+14 write enable, register index, write data
//
// One beat goes in and one comes out per tick, one tick per cycle while
// m_tready is high. A tick sits in the input register, then the per-servo
// step logic loads the pulse registers, which are the result register as well.
// The input register keeps taking beats while a result waits on m_tready;
// s_tready falls only when both registers are full and the output is stalled.
// Reset puts every pulse at 1500, the step at its slew_speed default and the
// custom targets at 90 degrees. Configuration writes take effect at once.
`include "assert_macros.svh"
module servo_pose_slew_limiter #(
	parameter int STEP_MS = 20
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [7:0]                    s_tdata,   // [2:0] pose
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// [11:0] first_pwm, [23:12] second_pwm, [35:24] third_pwm,
	// [47:36] fourth_pwm, [48] settled, [55:49] zero
	output logic [55:0]                   m_tdata,
	input  wire                           cfg_we,
	input  wire  [sps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [sps_pkg::SPEED_W-1:0]   cfg_wdata
);
	import sps_pkg::*;

	sps_cfg_t           cfg;
	logic [POSE_W-1:0]  pose_s1;
	logic               vld_s1;
	logic               out_vld_q;
	pulse_set_t         pulse_q;
	logic               settled_q;
	pulse_set_t         pulse_nxt;
	pulse_set_t         tgt_sel;
	logic [NUM_SERVOS-1:0] at_tgt;
	logic               hold_s1;
	logic               adv_s1;

	sps_cfg #(.STEP_MS(STEP_MS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	assign hold_s1  = pose_s1 > POSE_CUSTOM;
	assign adv_s1   = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv_s1;

	always_comb begin
		for (int i = 0; i < NUM_SERVOS; i++) begin
			if (pose_s1 < POSE_CUSTOM) begin
				tgt_sel[i] = PRESET_PULSE[pose_s1][i];
			end else begin
				tgt_sel[i] = cfg.custom_tgt[i];
			end
		end
	end

	for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_servo
		sps_step u_step (
			.cur_raw(pulse_q[g]),
			.tgt    (tgt_sel[g]),
			.hold   (hold_s1),
			.step   (cfg.step),
			.nxt    (pulse_nxt[g]),
			.at_tgt (at_tgt[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				pulse_q[i] <= PULSE_MID;
			end
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				out_vld_q <= 1'b1;
				pulse_q   <= pulse_nxt;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pose_s1 <= s_tdata[POSE_W-1:0];
		end
		if (adv_s1) begin
			settled_q <= &at_tgt;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, settled_q, pulse_q[3], pulse_q[2], pulse_q[1], pulse_q[0]};

	`ASSERT_SAME(a_stall_only_when_full, !s_tready, vld_s1 && out_vld_q && !m_tready,
		"input stalled while a register was free")
	`ASSERT_NEXT(a_pulse_moves_on_advance, !adv_s1, $stable(pulse_q),
		"servo pulses changed without a tick")
	`ASSERT_NEXT(a_hold_settles, adv_s1 && hold_s1, settled_q && m_tvalid,
		"hold pose did not report settled")

endmodule
`default_nettype wire

@@ dv/tb_servo_pose_slew_limiter.sv @@
module tb_servo_pose_slew_limiter;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	localparam int TICK_MS      = 20;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RAND_PHASES  = 19;
	localparam int PHASE_TICKS  = 50;
	localparam int CALM_FROM    = 16;

	// Indexes that no register answers to.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

	typedef enum logic [POSE_W-1:0] {
		POSE_HOME, POSE_OPEN, POSE_CLOSE, POSE_FLY, POSE_THROW, POSE_CUST,
		POSE_HOLD_A, POSE_HOLD_B
	} pose_e;

	typedef struct packed {
		logic [PULSE_W-1:0] first_pwm;
		logic [PULSE_W-1:0] second_pwm;
		logic [PULSE_W-1:0] third_pwm;
		logic [PULSE_W-1:0] fourth_pwm;
		logic               settled;
	} pose_out_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		pose_e                pose;
		logic                 typed;
		pose_out_t            want;
		logic [CFG_IDX_W-1:0] idx;
		logic [SPEED_W-1:0]   val;
	} stim_row_t;

	localparam pose_out_t NO_RESULT = '0;

	localparam int unsigned PRESET_DEG [5][4] = '{
		'{150, 150, 0, 90},
		'{60, 60, 45, 120},
		'{105, 105, 45, 120},
		'{105, 105, 0, 90},
		'{60, 60, 0, 90}
	};

	localparam stim_row_t DIRECTED_ROWS [30] = '{
		'{ROW_TICK, POSE_HOLD_A, 1'b1, '{1500, 1500, 1500, 1500, 1'b1}, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_HOME, 1'b1, '{1520, 1520, 1480, 1500, 1'b0}, CFG_SLEW_SPEED, 0},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 14'd0},
		'{ROW_TICK, POSE_HOME, 1'b1, '{1520, 1520, 1480, 1500, 1'b0}, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_HOLD_B, 1'b1, '{1520, 1520, 1480, 1500, 1'b1}, CFG_SLEW_SPEED, 0},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 14'd16383},
		'{ROW_TICK, POSE_HOME, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_HOME, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_HOME, 1'b1, '{2166, 2166, 500, 1500, 1'b1}, CFG_SLEW_SPEED, 0},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_CUSTOM_FIRST, 14'd255},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_CUSTOM_SECOND, 14'd0},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_CUSTOM_THIRD, 14'd180},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_CUSTOM_FOURTH, 14'h3FB5},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_UNUSED_LO, 14'h3FFF},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_UNUSED_HI, 14'h0000},
		'{ROW_TICK, POSE_CUST, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CUST, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CUST, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CUST, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CUST, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CUST, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CUST, 1'b1, '{2500, 500, 2500, 2500, 1'b1}, CFG_SLEW_SPEED, 0},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 14'd10000},
		'{ROW_TICK, POSE_OPEN, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_CLOSE, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_FLY, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_THROW, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_WRITE, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 14'd50},
		'{ROW_TICK, POSE_THROW, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0},
		'{ROW_TICK, POSE_HOLD_A, 1'b0, NO_RESULT, CFG_SLEW_SPEED, 0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [2:0] pose
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// [11:0] first_pwm, [23:12] second_pwm, [35:24] third_pwm,
	// [47:36] fourth_pwm, [48] settled
	logic [55:0]          m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SPEED_W-1:0]   cfg_wdata = '0;

	// Model copy of the block's settings and servo positions.
	int unsigned speed_setting = 1000;
	int unsigned custom_deg [4] = '{90, 90, 90, 90};
	int unsigned servo_us [4]   = '{1500, 1500, 1500, 1500};

	pose_out_t pending_pulses [$];
	int        errors    = 0;
	int        cycles    = 0;
	int        stall_left = 0;
	bit        calm      = 1'b0;

	servo_pose_slew_limiter #(
		.STEP_MS(TICK_MS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned deg_to_us(input int unsigned deg);
		if (deg > 180) begin
			deg = 180;
		end
		return 500 + (deg * 100) / 9;
	endfunction

	function automatic pose_out_t advance_servos(input pose_e p);
		int unsigned stride;
		int unsigned now;
		int unsigned aim;
		int unsigned after [4];
		pose_out_t   r;
		stride    = (speed_setting * TICK_MS) / 1000;
		r         = NO_RESULT;
		r.settled = 1'b1;
		for (int i = 0; i < 4; i++) begin
			now = (servo_us[i] < 500) ? 500 : ((servo_us[i] > 2500) ? 2500 : servo_us[i]);
			if (p < POSE_CUST) begin
				aim = deg_to_us(PRESET_DEG[p][i]);
			end else if (p == POSE_CUST) begin
				aim = deg_to_us(custom_deg[i]);
			end else begin
				aim = now;
			end
			if (aim > now) begin
				now = (aim - now <= stride) ? aim : now + stride;
			end else if (aim < now) begin
				now = (now - aim <= stride) ? aim : now - stride;
			end
			servo_us[i] = now;
			after[i]    = now;
			if (now != aim) begin
				r.settled = 1'b0;
			end
		end
		r.first_pwm  = PULSE_W'(after[0]);
		r.second_pwm = PULSE_W'(after[1]);
		r.third_pwm  = PULSE_W'(after[2]);
		r.fourth_pwm = PULSE_W'(after[3]);
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_SLEW_SPEED) begin
			speed_setting = val;
		end else if (idx >= CFG_CUSTOM_FIRST && idx <= CFG_CUSTOM_FOURTH) begin
			custom_deg[idx - CFG_CUSTOM_FIRST] = val[ANGLE_W-1:0];
		end
	endtask

	task automatic send_tick(input pose_e p, input logic typed, input pose_out_t want);
		pose_out_t model_out;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 8'(p);
		do @(posedge clk); while (!s_tready);
		model_out = advance_servos(p);
		pending_pulses.push_back(typed ? want : model_out);
	endtask

	// Holds the sender off until every expected beat has come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pulses.size() != 0);
	endtask

	always @(posedge clk) begin
		if (calm) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		pose_out_t want;
		pose_out_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.first_pwm  = m_tdata[11:0];
			got.second_pwm = m_tdata[23:12];
			got.third_pwm  = m_tdata[35:24];
			got.fourth_pwm = m_tdata[47:36];
			got.settled    = m_tdata[48];
			if (pending_pulses.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = pending_pulses.pop_front();
				if (got.first_pwm != want.first_pwm) begin
					$error("first_pwm: expected %0d, got %0d", want.first_pwm, got.first_pwm);
					errors++;
				end
				if (got.second_pwm != want.second_pwm) begin
					$error("second_pwm: expected %0d, got %0d", want.second_pwm,
						got.second_pwm);
					errors++;
				end
				if (got.third_pwm != want.third_pwm) begin
					$error("third_pwm: expected %0d, got %0d", want.third_pwm, got.third_pwm);
					errors++;
				end
				if (got.fourth_pwm != want.fourth_pwm) begin
					$error("fourth_pwm: expected %0d, got %0d", want.fourth_pwm,
						got.fourth_pwm);
					errors++;
				end
				if (got.settled != want.settled) begin
					$error("settled: expected %0d, got %0d", want.settled, got.settled);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_servo_pose_slew_limiter: done, errors");
			$finish;
		end
	end

	initial begin
		int                 sent;
		int                 run;
		int                 pick;
		pose_e              p;
		logic [SPEED_W-1:0] spd;
		logic [ANGLE_W-1:0] deg;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
				drain_results();
				write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].val);
			end else begin
				send_tick(DIRECTED_ROWS[r].pose, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_results();
			calm = (ph >= CALM_FROM) || ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 7))
					0: spd = 14'd0;
					1: spd = 14'd49;
					2: spd = 14'd16383;
					3: spd = 14'd10000;
					4: spd = SPEED_W'($urandom);
					default: spd = SPEED_W'($urandom_range(1500, 10000));
				endcase
				write_reg(CFG_SLEW_SPEED, spd);
			end
			for (int s = 0; s < 4; s++) begin
				if ($urandom_range(0, 1) == 1) begin
					// Angles past 180 now and then, and junk in the upper data bits every time.
					deg = ($urandom_range(0, 5) == 0) ? ANGLE_W'($urandom)
						: ANGLE_W'($urandom_range(0, 180));
					write_reg(CFG_IDX_W'(CFG_CUSTOM_FIRST + s), {6'($urandom), deg});
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
					SPEED_W'($urandom));
			end

			// Mostly runs toward one pose so the servos get to settle.
			sent = 0;
			while (sent < PHASE_TICKS) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					p   = pose_e'($urandom_range(POSE_HOME, POSE_CUST));
					run = $urandom_range(1, 30);
				end else if (pick < 9) begin
					p   = pose_e'($urandom_range(POSE_HOLD_A, POSE_HOLD_B));
					run = $urandom_range(1, 5);
				end else begin
					p   = pose_e'($urandom_range(0, 7));
					run = 1;
				end
				// Keep each phase at its tick count.
				if (run > PHASE_TICKS - sent) begin
					run = PHASE_TICKS - sent;
				end
				repeat (run) begin
					send_tick(p, 1'b0, NO_RESULT);
					sent++;
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb_servo_pose_slew_limiter: done, clean");
		end else begin
			$display("tb_servo_pose_slew_limiter: done, errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sps_pkg.sv
hdl/sps_cfg.sv
hdl/sps_step.sv
hdl/servo_pose_slew_limiter.sv
dv/tb_servo_pose_slew_limiter.sv
